// ===== src/bpc_pkg.sv =====
// Shared types and constants for the barometric pressure compensation core.
// Used by every module of the block; depends on nothing.
package bpc_pkg;

   // Field widths
   localparam int RAW_W   = 24;
   localparam int COEF_W  = 16;
   localparam int PRESS_W = 32;
   localparam int TEMP_W  = 16;

   // Register port
   localparam int ADDR_W  = 5;
   localparam int IDX_LSB = 2;
   localparam int DATA_W  = 32;

   localparam logic [2:0] REG_PRESS_SENS  = 3'd0;
   localparam logic [2:0] REG_PRESS_OFF   = 3'd1;
   localparam logic [2:0] REG_SENS_TEMP   = 3'd2;
   localparam logic [2:0] REG_OFF_TEMP    = 3'd3;
   localparam logic [2:0] REG_REF_TEMP    = 3'd4;
   localparam logic [2:0] REG_TEMP_SLOPE  = 3'd5;

   // Scaling of the calibration words and of the products
   localparam int C5_SHIFT    = 8;
   localparam int C2_SHIFT    = 16;
   localparam int C1_SHIFT    = 15;
   localparam int TEMP_SHIFT  = 23;
   localparam int OFF_SHIFT   = 7;
   localparam int SENS_SHIFT  = 8;
   localparam int T2_SHIFT    = 31;
   localparam int P_SHIFT_LO  = 21;
   localparam int P_SHIFT_HI  = 15;

   // Internal widths
   localparam int DT_W    = RAW_W + 1;
   localparam int PROD_W  = DT_W + COEF_W + 1;
   localparam int SQ_W    = 2 * DT_W;
   localparam int TDLT_W  = PROD_W - TEMP_SHIFT;
   localparam int OFF_W   = 36;
   localparam int SENS_W  = 35;
   localparam int T2_W    = SQ_W - 1 - T2_SHIFT;
   localparam int SQA_W   = 35;
   localparam int CORR_W  = 39;
   localparam int NET_W   = 41;
   localparam int TC_W    = 20;
   localparam int TMAG_W  = 19;
   localparam int RECIP_W = 20;
   localparam int RECIP_SHIFT = 23;
   localparam int TPROD_W = TMAG_W + RECIP_W;
   localparam int LO_W    = 20;
   localparam int HI_W    = NET_W - LO_W;
   localparam int LOP_W   = RAW_W + LO_W;
   localparam int HIP_W   = RAW_W + 1 + HI_W;
   localparam int X_W     = RAW_W + NET_W + 1;
   localparam int PD_W    = PRESS_W + P_SHIFT_HI;

   // 20.00 C, and the span from 20.00 C down to -15.00 C
   localparam logic signed [TDLT_W-1:0] TEMP_BASE = 19'sd2000;
   localparam logic signed [TDLT_W-1:0] COLD_SPAN = 19'sd3500;

   // ceil(2^23 / 10): exact quotient by ten for magnitudes below 2^22
   localparam logic [RECIP_W-1:0] RECIP_TEN = 20'd838861;

   typedef struct packed {
      logic [COEF_W-1:0] press_sens;
      logic [COEF_W-1:0] press_offset;
      logic [COEF_W-1:0] sens_temp;
      logic [COEF_W-1:0] offset_temp;
      logic [COEF_W-1:0] ref_temp;
      logic [COEF_W-1:0] temp_slope;
   } coef_type;

   typedef struct packed {
      logic [RAW_W-1:0]         d1;
      logic signed [TDLT_W-1:0] tdlt;
      logic signed [TDLT_W-1:0] cold_dlt;
      logic                     is_cold;
      logic                     is_frigid;
      logic signed [OFF_W-1:0]  off;
      logic signed [SENS_W-1:0] sens;
      logic [T2_W-1:0]          t2;
   } front_type;

   typedef struct packed {
      logic [RAW_W-1:0]        d1;
      logic signed [NET_W-1:0] sens_net;
      logic signed [NET_W-1:0] off_net;
      logic                    tneg;
      logic [TMAG_W-1:0]       tmag;
   } corr_type;

endpackage

// ===== src/bpc_csr.sv =====
// Calibration register bank behind the APB-style configuration port.
// Depends on bpc_pkg for the register indexes and the coefficient struct.
module bpc_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bpc_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [bpc_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [bpc_pkg::DATA_W-1:0]    csr_prdata,
   output logic                          csr_pready,
   output bpc_pkg::coef_type             coef
);

   localparam int DW = bpc_pkg::DATA_W;

   bpc_pkg::coef_type coef_ff, coef_in;
   logic              wr_en;
   logic [2:0]        idx;
   logic [bpc_pkg::COEF_W-1:0] wval;
   logic [bpc_pkg::COEF_W-1:0] rval;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite;
   assign idx   = csr_paddr[bpc_pkg::ADDR_W-1:bpc_pkg::IDX_LSB];
   assign wval  = csr_pwdata[bpc_pkg::COEF_W-1:0];

   always_comb begin
      coef_in = coef_ff;
      if (wr_en) begin
         unique case (idx)
            bpc_pkg::REG_PRESS_SENS: coef_in.press_sens   = wval;
            bpc_pkg::REG_PRESS_OFF:  coef_in.press_offset = wval;
            bpc_pkg::REG_SENS_TEMP:  coef_in.sens_temp    = wval;
            bpc_pkg::REG_OFF_TEMP:   coef_in.offset_temp  = wval;
            bpc_pkg::REG_REF_TEMP:   coef_in.ref_temp     = wval;
            bpc_pkg::REG_TEMP_SLOPE: coef_in.temp_slope   = wval;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         bpc_pkg::REG_PRESS_SENS: rval = coef_ff.press_sens;
         bpc_pkg::REG_PRESS_OFF:  rval = coef_ff.press_offset;
         bpc_pkg::REG_SENS_TEMP:  rval = coef_ff.sens_temp;
         bpc_pkg::REG_OFF_TEMP:   rval = coef_ff.offset_temp;
         bpc_pkg::REG_REF_TEMP:   rval = coef_ff.ref_temp;
         bpc_pkg::REG_TEMP_SLOPE: rval = coef_ff.temp_slope;
         default:                 rval = '0;
      endcase
   end

   assign csr_prdata = DW'(rval);

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

// ===== src/bpc_front.sv =====
// First-order terms: temperature difference, its products with the
// calibration words, offset, sensitivity and the dT^2 term. Uses bpc_pkg.
module bpc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  bpc_pkg::coef_type          coef,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [bpc_pkg::RAW_W-1:0]  in_d1,
   input  logic [bpc_pkg::RAW_W-1:0]  in_d2,
   output logic                       out_valid,
   input  logic                       out_ready,
   output bpc_pkg::front_type         out_data
);

   localparam int RW = bpc_pkg::RAW_W;
   localparam int DW = bpc_pkg::DT_W;
   localparam int PW = bpc_pkg::PROD_W;
   localparam int QW = bpc_pkg::SQ_W;
   localparam int OW = bpc_pkg::OFF_W;
   localparam int SW = bpc_pkg::SENS_W;

   logic [2:0] vld_ff, vld_in, adv;

   // stage 1
   logic signed [DW-1:0] dt_ff, dt_in;
   logic [RW-1:0]        d1_a_ff;
   // stage 2
   logic signed [PW-1:0] p_temp_ff, p_temp_in;
   logic signed [PW-1:0] p_off_ff, p_off_in;
   logic signed [PW-1:0] p_sens_ff, p_sens_in;
   logic signed [QW-1:0] p_sq_ff, p_sq_in;
   logic [RW-1:0]        d1_b_ff;
   // stage 3
   bpc_pkg::front_type   front_ff, front_in;

   always_comb begin
      adv[2] = !vld_ff[2] || out_ready;
      adv[1] = !vld_ff[1] || adv[2];
      adv[0] = !vld_ff[0] || adv[1];
      vld_in[0] = adv[0] ? in_valid  : vld_ff[0];
      vld_in[1] = adv[1] ? vld_ff[0] : vld_ff[1];
      vld_in[2] = adv[2] ? vld_ff[1] : vld_ff[2];
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[2];
   assign out_data  = front_ff;

   assign dt_in = $signed({1'b0, in_d2}) -
                  $signed({1'b0, RW'(coef.ref_temp) << bpc_pkg::C5_SHIFT});

   assign p_temp_in = dt_ff * $signed({1'b0, coef.temp_slope});
   assign p_off_in  = dt_ff * $signed({1'b0, coef.offset_temp});
   assign p_sens_in = dt_ff * $signed({1'b0, coef.sens_temp});
   assign p_sq_in   = dt_ff * dt_ff;

   always_comb begin
      front_in.d1   = d1_b_ff;
      // floor division by a power of two is the upper bits
      front_in.tdlt = $signed(p_temp_ff[PW-1:bpc_pkg::TEMP_SHIFT]);
      front_in.cold_dlt = front_in.tdlt + bpc_pkg::COLD_SPAN;
      front_in.is_cold   = front_in.tdlt[bpc_pkg::TDLT_W-1];
      front_in.is_frigid = front_in.cold_dlt[bpc_pkg::TDLT_W-1];
      front_in.off  = $signed(OW'(coef.press_offset) << bpc_pkg::C2_SHIFT) +
                      OW'($signed(p_off_ff[PW-1:bpc_pkg::OFF_SHIFT]));
      front_in.sens = $signed(SW'(coef.press_sens) << bpc_pkg::C1_SHIFT) +
                      SW'($signed(p_sens_ff[PW-1:bpc_pkg::SENS_SHIFT]));
      front_in.t2   = p_sq_ff[QW-2:bpc_pkg::T2_SHIFT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         dt_ff   <= dt_in;
         d1_a_ff <= in_d1;
      end
      if (adv[1]) begin
         p_temp_ff <= p_temp_in;
         p_off_ff  <= p_off_in;
         p_sens_ff <= p_sens_in;
         p_sq_ff   <= p_sq_in;
         d1_b_ff   <= d1_a_ff;
      end
      if (adv[2]) begin
         front_ff <= front_in;
      end
   end

endmodule

// ===== src/bpc_corr.sv =====
// Second-order correction below 20.00 C, with the extra term below -15.00 C,
// and the corrected offset, sensitivity and temperature. Uses bpc_pkg.
module bpc_corr (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  bpc_pkg::front_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output bpc_pkg::corr_type  out_data
);

   localparam int TW  = bpc_pkg::TDLT_W;
   localparam int AW  = bpc_pkg::SQA_W;
   localparam int KW  = bpc_pkg::CORR_W;
   localparam int NW  = bpc_pkg::NET_W;
   localparam int CW  = bpc_pkg::TC_W;
   localparam int MW  = bpc_pkg::TMAG_W;

   logic [2:0] vld_ff, vld_in, adv;

   // stage 1: squares
   bpc_pkg::front_type   fr_a_ff;
   logic signed [2*TW-1:0] a_sq, b_sq;
   logic [AW-1:0]        a2_ff, b2_ff;
   // stage 2: correction terms
   bpc_pkg::front_type   fr_b_ff;
   logic [KW-1:0]        ea, eb, five_a2, seven_b2, eleven_b2;
   logic [KW-1:0]        off2_ff, off2_in, sens2_ff, sens2_in;
   logic signed [CW-1:0] tc_ff, tc_in;
   // stage 3
   bpc_pkg::corr_type    corr_ff, corr_in;

   always_comb begin
      adv[2] = !vld_ff[2] || out_ready;
      adv[1] = !vld_ff[1] || adv[2];
      adv[0] = !vld_ff[0] || adv[1];
      vld_in[0] = adv[0] ? in_valid  : vld_ff[0];
      vld_in[1] = adv[1] ? vld_ff[0] : vld_ff[1];
      vld_in[2] = adv[2] ? vld_ff[1] : vld_ff[2];
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[2];
   assign out_data  = corr_ff;

   assign a_sq = in_data.tdlt * in_data.tdlt;
   assign b_sq = in_data.cold_dlt * in_data.cold_dlt;

   always_comb begin
      ea        = KW'(a2_ff);
      eb        = KW'(b2_ff);
      five_a2   = (ea << 2) + ea;
      seven_b2  = (eb << 3) - eb;
      eleven_b2 = (eb << 3) + (eb << 1) + eb;
      off2_in   = '0;
      sens2_in  = '0;
      if (fr_a_ff.is_cold) begin
         off2_in  = five_a2 >> 1;
         sens2_in = five_a2 >> 2;
         if (fr_a_ff.is_frigid) begin
            off2_in  = off2_in + seven_b2;
            sens2_in = sens2_in + (eleven_b2 >> 1);
         end
      end
      tc_in = CW'(fr_a_ff.tdlt) + CW'(bpc_pkg::TEMP_BASE) -
              (fr_a_ff.is_cold ? $signed(CW'(fr_a_ff.t2)) : $signed(CW'(1'b0)));
   end

   always_comb begin
      corr_in.d1       = fr_b_ff.d1;
      corr_in.sens_net = NW'(fr_b_ff.sens) - $signed(NW'(sens2_ff));
      corr_in.off_net  = NW'(fr_b_ff.off) - $signed(NW'(off2_ff));
      corr_in.tneg     = tc_ff[CW-1];
      corr_in.tmag     = tc_ff[CW-1] ? MW'(-tc_ff) : MW'(tc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         fr_a_ff <= in_data;
         a2_ff   <= a_sq[AW-1:0];
         b2_ff   <= b_sq[AW-1:0];
      end
      if (adv[1]) begin
         fr_b_ff  <= fr_a_ff;
         off2_ff  <= off2_in;
         sens2_ff <= sens2_in;
         tc_ff    <= tc_in;
      end
      if (adv[2]) begin
         corr_ff <= corr_in;
      end
   end

endmodule

// ===== src/bpc_scale.sv =====
// Final scaling: split pressure product, offset subtraction and the
// temperature quotient by ten. Holds the result register. Uses bpc_pkg.
module bpc_scale (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  bpc_pkg::corr_type                   in_data,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic signed [bpc_pkg::PRESS_W-1:0]  out_pressure,
   output logic signed [bpc_pkg::TEMP_W-1:0]   out_temperature
);

   localparam int NW  = bpc_pkg::NET_W;
   localparam int LW  = bpc_pkg::LO_W;
   localparam int LPW = bpc_pkg::LOP_W;
   localparam int HPW = bpc_pkg::HIP_W;
   localparam int XW  = bpc_pkg::X_W;
   localparam int DW  = bpc_pkg::PD_W;
   localparam int QW  = bpc_pkg::TPROD_W;
   localparam int TW  = bpc_pkg::TEMP_W;

   logic [2:0] vld_ff, vld_in, adv;

   // stage 1: partial products
   logic [LPW-1:0]        lo_p_ff, lo_p_in;
   logic signed [HPW-1:0] hi_p_ff, hi_p_in;
   logic [QW-1:0]         tq_p_ff, tq_p_in;
   logic signed [NW-1:0]  off_a_ff;
   logic                  tneg_ff;
   // stage 2: combine
   logic signed [XW-1:0]  x_ff, x_in;
   logic signed [NW-1:0]  off_b_ff;
   logic [TW-1:0]         tq;
   logic [TW-1:0]         temp_b_ff, temp_b_in;
   // stage 3: result register
   logic signed [DW-1:0]  diff;
   logic signed [bpc_pkg::PRESS_W-1:0] press_ff;
   logic signed [TW-1:0]  temp_ff;

   always_comb begin
      adv[2] = !vld_ff[2] || out_ready;
      adv[1] = !vld_ff[1] || adv[2];
      adv[0] = !vld_ff[0] || adv[1];
      vld_in[0] = adv[0] ? in_valid  : vld_ff[0];
      vld_in[1] = adv[1] ? vld_ff[0] : vld_ff[1];
      vld_in[2] = adv[2] ? vld_ff[1] : vld_ff[2];
   end

   assign in_ready        = adv[0];
   assign out_valid       = vld_ff[2];
   assign out_pressure    = press_ff;
   assign out_temperature = temp_ff;

   assign lo_p_in = in_data.d1 * in_data.sens_net[LW-1:0];
   assign hi_p_in = $signed({1'b0, in_data.d1}) * $signed(in_data.sens_net[NW-1:LW]);
   assign tq_p_in = in_data.tmag * bpc_pkg::RECIP_TEN;

   assign x_in = (XW'(hi_p_ff) <<< LW) + $signed(XW'(lo_p_ff));
   assign tq   = tq_p_ff[QW-1:bpc_pkg::RECIP_SHIFT];
   // truncate toward zero: divide the magnitude, then restore the sign
   assign temp_b_in = tneg_ff ? -tq : tq;

   assign diff = DW'($signed(x_ff[XW-1:bpc_pkg::P_SHIFT_LO])) - DW'(off_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         lo_p_ff  <= lo_p_in;
         hi_p_ff  <= hi_p_in;
         tq_p_ff  <= tq_p_in;
         off_a_ff <= in_data.off_net;
         tneg_ff  <= in_data.tneg;
      end
      if (adv[1]) begin
         x_ff      <= x_in;
         off_b_ff  <= off_a_ff;
         temp_b_ff <= temp_b_in;
      end
      if (adv[2]) begin
         press_ff <= diff[DW-1:bpc_pkg::P_SHIFT_HI];
         temp_ff  <= $signed(temp_b_ff);
      end
   end

endmodule

// ===== src/baro_pressure_compensation_core.sv =====
// Channel  | Direction | Handshake           | Payload
// req      | in        | req_valid/req_ready | req_raw_pressure, req_raw_temperature
// rsp      | out       | rsp_valid/rsp_ready | rsp_pressure_out, rsp_temperature_out
// csr      | in/out    | APB-style, pready=1 | six 16-bit calibration words
//
// One transfer per cycle in and out while rsp_ready is high. Nine register
// stages, three per section (front, correction, scaling); rsp_valid rises
// once a request has passed through the front, correction and scaling stages.
// Synchronous reset clears all stage valid bits and the calibration words.
// A stage holds only while the stage after it is full and stalled; empty
// stages keep taking requests while a result waits in the output register.
module baro_pressure_compensation_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bpc_pkg::RAW_W-1:0]           req_raw_pressure,
   input  logic [bpc_pkg::RAW_W-1:0]           req_raw_temperature,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [bpc_pkg::PRESS_W-1:0]  rsp_pressure_out,
   output logic signed [bpc_pkg::TEMP_W-1:0]   rsp_temperature_out,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [bpc_pkg::ADDR_W-1:0]          csr_paddr,
   input  logic [bpc_pkg::DATA_W-1:0]          csr_pwdata,
   output logic [bpc_pkg::DATA_W-1:0]          csr_prdata,
   output logic                                csr_pready
);

   bpc_pkg::coef_type  coef;
   logic               front_valid, front_ready;
   bpc_pkg::front_type front_data;
   logic               corr_valid, corr_ready;
   bpc_pkg::corr_type  corr_data;

   bpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coef        (coef)
   );

   bpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_d1     (req_raw_pressure),
      .in_d2     (req_raw_temperature),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   bpc_corr u_corr (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (corr_valid),
      .out_ready (corr_ready),
      .out_data  (corr_data)
   );

   bpc_scale u_scale (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (corr_valid),
      .in_ready        (corr_ready),
      .in_data         (corr_data),
      .out_valid       (rsp_valid),
      .out_ready       (rsp_ready),
      .out_pressure    (rsp_pressure_out),
      .out_temperature (rsp_temperature_out)
   );

endmodule

// ===== src/bpc_checker.sv =====
// Port-level checks for the compensation core, with the bind that attaches
// them to the top level. Tracks transfers in flight; uses bpc_pkg widths.
module bpc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [bpc_pkg::PRESS_W-1:0]  rsp_pressure_out,
   input logic signed [bpc_pkg::TEMP_W-1:0]   rsp_temperature_out
);

   localparam int CNT_W = 4;
   localparam logic [CNT_W-1:0] DEPTH = 4'd9;

   logic [CNT_W-1:0] inflight_ff, inflight_in;
   logic             acc_in, acc_out;

   assign acc_in  = req_valid && req_ready;
   assign acc_out = rsp_valid && rsp_ready;
   assign inflight_in = inflight_ff + CNT_W'(acc_in) - CNT_W'(acc_out);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_pressure_out) && $stable(rsp_temperature_out))
      else $error("stalled result changed or dropped");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != '0)
      else $error("result without an accepted request");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= DEPTH)
      else $error("more transfers in flight than pipeline stages");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      inflight_ff == DEPTH && !rsp_ready |-> !req_ready)
      else $error("request taken while the full pipeline is stalled");

endmodule

bind baro_pressure_compensation_core bpc_checker u_bpc_checker (.*);

// ===== test/tb_baro_pressure_compensation_core.sv =====
// Self-checking testbench for baro_pressure_compensation_core: directed probe table,
// then randomized phases with sender/receiver idling and calibration reloads.
// Depends on bpc_pkg and the core; predicts every unpinned result with its own compensation model.
`timescale 1ns / 1ps

module tb_baro_pressure_compensation_core;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 140;
   localparam int QUIET_LIMIT     = 5000;
   localparam int DRAIN_CYCLES    = 20;
   localparam int PROBE_ROWS      = 18;

   localparam int RW  = bpc_pkg::RAW_W;
   localparam int PW  = bpc_pkg::PRESS_W;
   localparam int TW  = bpc_pkg::TEMP_W;
   localparam int CFW = bpc_pkg::COEF_W;
   localparam int AW  = bpc_pkg::ADDR_W;
   localparam int DW  = bpc_pkg::DATA_W;

   // Indexes past the last calibration word: writes must be dropped
   localparam logic [2:0] REG_UNMAPPED_0 = 3'd6;
   localparam logic [2:0] REG_UNMAPPED_1 = 3'd7;

   typedef enum logic [2:0] {
      CAL_RESET, CAL_TYPICAL, CAL_EDGE, CAL_MAX, CAL_NEG_PRESS
   } cal_set_type;

   typedef struct packed {
      logic signed [PW-1:0] pressure;
      logic signed [TW-1:0] temperature;
   } reading_type;

   typedef struct packed {
      cal_set_type   cal;
      logic [RW-1:0] raw_p;
      logic [RW-1:0] raw_t;
      logic          pinned;
      reading_type   pin;
   } probe_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [RW-1:0]        req_raw_pressure = '0;
   logic [RW-1:0]        req_raw_temperature = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic signed [PW-1:0] rsp_pressure_out;
   logic signed [TW-1:0] rsp_temperature_out;
   logic                 csr_psel = 1'b0;
   logic                 csr_penable = 1'b0;
   logic                 csr_pwrite = 1'b0;
   logic [AW-1:0]        csr_paddr = '0;
   logic [DW-1:0]        csr_pwdata = '0;
   logic [DW-1:0]        csr_prdata;
   logic                 csr_pready;

   bpc_pkg::coef_type cal_now = '0;
   reading_type       expected_readings[$];
   reading_type       rsp_want;
   int                mismatch_count = 0;
   int                quiet_cycles = 0;
   int                send_idle_pct = 0;
   int                stall_pct = 0;

   // Rows at reset and with zero sensitivity can be worked out by hand
   probe_row_type probe_rows [PROBE_ROWS] = '{
      '{CAL_RESET,     24'h000000, 24'h000000, 1'b1, '{32'sd0, 16'sd200}},
      '{CAL_RESET,     24'hFFFFFF, 24'hFFFFFF, 1'b1, '{32'sd0, 16'sd200}},
      '{CAL_RESET,     24'h800000, 24'h7FFFFF, 1'b1, '{32'sd0, 16'sd200}},
      '{CAL_TYPICAL,   24'd9085466, 24'd8569150, 1'b0, '0},
      '{CAL_TYPICAL,   24'h000000, 24'h000000, 1'b0, '0},
      '{CAL_TYPICAL,   24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
      '{CAL_TYPICAL,   24'd123456, 24'd8000000, 1'b0, '0},
      '{CAL_EDGE,      24'd5000000, 24'd8388608, 1'b0, '0},
      '{CAL_EDGE,      24'd5000000, 24'd8388607, 1'b0, '0},
      '{CAL_EDGE,      24'd5000000, 24'd7492608, 1'b0, '0},
      '{CAL_EDGE,      24'd5000000, 24'd7492607, 1'b0, '0},
      '{CAL_EDGE,      24'h000000, 24'd7872768, 1'b0, '0},
      '{CAL_EDGE,      24'hFFFFFF, 24'h000000, 1'b0, '0},
      '{CAL_MAX,       24'hFFFFFF, 24'hFFFFFF, 1'b0, '0},
      '{CAL_MAX,       24'h000000, 24'h000000, 1'b0, '0},
      '{CAL_MAX,       24'hFFFFFF, 24'h000000, 1'b0, '0},
      '{CAL_NEG_PRESS, 24'hFFFFFF, 24'h000000, 1'b1, '{-32'sd131070, 16'sd200}},
      '{CAL_NEG_PRESS, 24'h000000, 24'hFFFFFF, 1'b0, '0}
   };

   baro_pressure_compensation_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_raw_pressure    (req_raw_pressure),
      .req_raw_temperature (req_raw_temperature),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pressure_out    (rsp_pressure_out),
      .rsp_temperature_out (rsp_temperature_out),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Signed right shifts on longint floor toward minus infinity
   function automatic reading_type compensate_reading(input bpc_pkg::coef_type cal,
                                                      input logic [RW-1:0] d1_raw,
                                                      input logic [RW-1:0] d2_raw);
      longint d1, d2, c1, c2, c3, c4, c5, c6;
      longint dt, tc, off, sens, t2, off2, sens2, dev, cold, pr, tq;
      reading_type r;
      d1 = d1_raw;
      d2 = d2_raw;
      c1 = cal.press_sens;
      c2 = cal.press_offset;
      c3 = cal.sens_temp;
      c4 = cal.offset_temp;
      c5 = cal.ref_temp;
      c6 = cal.temp_slope;
      dt = d2 - c5 * 256;
      tc = 2000 + ((dt * c6) >>> 23);
      off = c2 * 65536 + ((c4 * dt) >>> 7);
      sens = c1 * 32768 + ((c3 * dt) >>> 8);
      t2 = 0;
      off2 = 0;
      sens2 = 0;
      if (tc < 2000) begin
         dev = tc - 2000;
         t2 = (dt * dt) >>> 31;
         off2 = (5 * dev * dev) >>> 1;
         sens2 = (5 * dev * dev) >>> 2;
         if (tc < -1500) begin
            cold = tc + 1500;
            off2 += 7 * cold * cold;
            sens2 += (11 * cold * cold) >>> 1;
         end
      end
      tc -= t2;
      off -= off2;
      sens -= sens2;
      pr = (((d1 * sens) >>> 21) - off) >>> 15;
      tq = tc / 10;
      r.pressure = pr[PW-1:0];
      r.temperature = tq[TW-1:0];
      return r;
   endfunction

   function automatic logic [CFW-1:0] coef_at(input bpc_pkg::coef_type cal,
                                              input logic [2:0] idx);
      unique case (idx)
         bpc_pkg::REG_PRESS_SENS: return cal.press_sens;
         bpc_pkg::REG_PRESS_OFF:  return cal.press_offset;
         bpc_pkg::REG_SENS_TEMP:  return cal.sens_temp;
         bpc_pkg::REG_OFF_TEMP:   return cal.offset_temp;
         bpc_pkg::REG_REF_TEMP:   return cal.ref_temp;
         bpc_pkg::REG_TEMP_SLOPE: return cal.temp_slope;
         default:                 return '0;
      endcase
   endfunction

   function automatic bpc_pkg::coef_type cal_preset(input cal_set_type s);
      unique case (s)
         CAL_TYPICAL:
            return '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
         // 256*ref equals 2^23 and the slope is 2^15: one temperature step per 256 counts
         CAL_EDGE:
            return '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd32768, 16'd32768};
         CAL_MAX:       return '1;
         CAL_NEG_PRESS: return '{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0};
         default:       return '0;
      endcase
   endfunction

   // Leaves psel high so back-to-back accesses never lower and raise it in one step
   task automatic csr_access(input logic [2:0] idx, input logic is_write,
                             input logic [DW-1:0] wdata, output logic [DW-1:0] rdata);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
   endtask

   task automatic csr_release();
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_calibration(input bpc_pkg::coef_type cal);
      logic [DW-1:0] rdata;
      for (int i = bpc_pkg::REG_PRESS_SENS; i <= bpc_pkg::REG_TEMP_SLOPE; i++)
         csr_access(i[2:0], 1'b1, {16'($urandom), coef_at(cal, i[2:0])}, rdata);
      csr_access(REG_UNMAPPED_0, 1'b1, $urandom, rdata);
      csr_access(REG_UNMAPPED_1, 1'b1, $urandom, rdata);
      cal_now = cal;
      csr_release();
      for (int i = bpc_pkg::REG_PRESS_SENS; i <= bpc_pkg::REG_TEMP_SLOPE; i++) begin
         csr_access(i[2:0], 1'b0, '0, rdata);
         if (rdata[CFW-1:0] !== coef_at(cal_now, i[2:0])) begin
            $display("%0t: register %0d readback mismatch, expected %0h, actual %0h",
                     $time, i, coef_at(cal_now, i[2:0]), rdata[CFW-1:0]);
            mismatch_count++;
         end
      end
      csr_release();
   endtask

   // Valid stays high on return; the caller lowers it only before idling
   task automatic transfer_reading(input logic [RW-1:0] raw_p, input logic [RW-1:0] raw_t,
                                   input logic pinned, input reading_type pin);
      req_valid <= 1'b1;
      req_raw_pressure <= raw_p;
      req_raw_temperature <= raw_t;
      do @(posedge clock); while (!req_ready);
      expected_readings.push_back(pinned ? pin : compensate_reading(cal_now, raw_p, raw_t));
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (expected_readings.size() != 0);
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            $display("%0t: result with nothing pending, expected none, actual %0d / %0d",
                     $time, rsp_pressure_out, rsp_temperature_out);
            mismatch_count++;
         end else begin
            rsp_want = expected_readings.pop_front();
            if (rsp_pressure_out !== rsp_want.pressure) begin
               $display("%0t: pressure_out mismatch, expected %0d, actual %0d",
                        $time, rsp_want.pressure, rsp_pressure_out);
               mismatch_count++;
            end
            if (rsp_temperature_out !== rsp_want.temperature) begin
               $display("%0t: temperature_out mismatch, expected %0d, actual %0d",
                        $time, rsp_want.temperature, rsp_temperature_out);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_psel && csr_penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : stimulus
      probe_row_type     row;
      cal_set_type       cal_sel;
      bpc_pkg::coef_type next_cal;
      logic [RW-1:0]     rp;
      logic [RW-1:0]     rt;
      int                center;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cal_sel = CAL_RESET;
      for (int i = 0; i < PROBE_ROWS; i++) begin
         row = probe_rows[i];
         if (row.cal != cal_sel) begin
            req_valid <= 1'b0;
            wait_drained();
            load_calibration(cal_preset(row.cal));
            cal_sel = row.cal;
         end
         transfer_reading(row.raw_p, row.raw_t, row.pinned, row.pin);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         req_valid <= 1'b0;
         wait_drained();
         if (ph == 0)
            next_cal = '1;
         else if (ph == 5)
            next_cal = '0;
         else
            next_cal = bpc_pkg::coef_type'({$urandom, $urandom, $urandom});
         load_calibration(next_cal);
         unique case (ph % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 66; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 66; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // in odd phases, hold the sender until the pipeline is empty, mid-phase
            if (n == ITEMS_PER_PHASE / 2 && ph % 2 == 1) begin
               req_valid <= 1'b0;
               wait_drained();
            end else begin
               while ($urandom_range(99) < send_idle_pct) begin
                  req_valid <= 1'b0;
                  @(posedge clock);
               end
            end
            if ($urandom_range(15) == 0)
               rp = $urandom_range(1) ? {RW{1'b1}} : '0;
            else
               rp = RW'($urandom_range(24'hFFFFFF));
            // a third of the readings sit near the reference temperature
            if ($urandom_range(2) == 0) begin
               center = int'(cal_now.ref_temp) * 256 + int'($urandom_range(8192)) - 4096;
               if (center < 0)
                  center = 0;
               if (center > 24'hFFFFFF)
                  center = 24'hFFFFFF;
               rt = center[RW-1:0];
            end else begin
               rt = RW'($urandom_range(24'hFFFFFF));
            end
            transfer_reading(rp, rt, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
